// ===== sv/edfa_pkg.sv =====
// shared types and constants of the enumerative dfa runner
package edfa_pkg;

  localparam int STATE_W     = 6;
  localparam int CLASS_W     = 6;
  localparam int MAP_W       = 5;
  localparam int MAX_STATES  = 64;
  localparam int MAX_CLASSES = 32;
  localparam int TABLE_DEPTH = (MAX_CLASSES + 1) * MAX_STATES;
  localparam int TABLE_AW    = CLASS_W + STATE_W;

  localparam logic [7:0] CHAR_WILD  = 8'h5E;
  localparam logic [7:0] CHAR_BAR   = 8'h7C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [0:0] CFG_STATES  = 1'b0;
  localparam logic [0:0] CFG_CLASSES = 1'b1;

  localparam logic RES_ACK   = 1'b0;
  localparam logic RES_FINAL = 1'b1;

  typedef enum logic [1:0] {
    REQ_CLEAR, REQ_RULE, REQ_TEXT, REQ_END
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK, ERR_STATE, ERR_CLASS
  } rule_err_t;

  typedef enum logic [2:0] {
    OP_CLEAR, OP_WRITE, OP_WILD, OP_STEP, OP_ACK, OP_REPORT
  } op_kind_t;

  typedef enum logic [1:0] {
    B_SWEEP, B_IDLE, B_WILD, B_LOOK
  } back_state_t;

  typedef struct packed {
    logic [6:0]         state_count;
    logic [CLASS_W-1:0] class_count;
  } cfg_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [CLASS_W-1:0] cls;
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] dst;
    rule_err_t          err;
  } op_t;

  typedef struct packed {
    logic               kind;
    logic [STATE_W-1:0] state;
    rule_err_t          err;
  } res_t;

endpackage

// ===== sv/edfa_queue.sv =====
// two-entry queue used between front and back and for results
module edfa_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output T     rdata
);
  import edfa_pkg::*;

  T           mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= wdata;
  end

endmodule

// ===== sv/edfa_front.sv =====
// front end: character classes, rule checks and request classification
module edfa_front (
  input  logic          clk,
  input  logic          rst,
  input  edfa_pkg::cfg_t cfg,
  input  logic          push,
  input  logic          hold,
  output logic          full,
  input  logic [1:0]    req_type,
  input  logic [5:0]    rule_src,
  input  logic [7:0]    rule_char,
  input  logic [5:0]    rule_dst,
  input  logic [7:0]    text_char,
  input  logic          op_full,
  output logic          op_push,
  output edfa_pkg::op_t op
);
  import edfa_pkg::*;

  logic               busy;
  req_t               req;
  logic [STATE_W-1:0] src;
  logic [STATE_W-1:0] dst;
  logic [7:0]         ch;
  logic [MAP_W-1:0]   map_rd;
  logic               map_hit;
  logic [MAP_W-1:0]   class_map [256];
  logic [255:0]       map_valid;
  logic [CLASS_W-1:0] next_class;
  logic               accept;
  logic [7:0]         ch_in;
  logic [CLASS_W-1:0] cls_raw;
  logic               bad_state;
  logic               map_we;
  logic               do_clear;

  assign accept = push && !full;
  assign full   = busy || hold;

  always_comb begin
    ch_in = rule_char;
    if (req_t'(req_type) == REQ_TEXT) ch_in = (text_char == CHAR_SPACE) ? CHAR_BAR : text_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (op_push) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= req_t'(req_type);
      src     <= rule_src;
      dst     <= rule_dst;
      ch      <= ch_in;
      map_rd  <= class_map[ch_in];
      map_hit <= map_valid[ch_in];
    end
    if (map_we) class_map[ch] <= next_class[MAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      map_valid  <= '0;
      next_class <= '0;
    end else if (map_we) begin
      map_valid[ch] <= 1'b1;
      next_class    <= next_class + 1'b1;
    end
  end

  assign cls_raw   = map_hit ? {1'b0, map_rd} : next_class;
  assign bad_state = ({1'b0, src} >= cfg.state_count) || ({1'b0, dst} >= cfg.state_count);
  assign op_push   = busy && !op_full;
  assign do_clear  = op_push && req == REQ_CLEAR;

  always_comb begin
    op      = '{kind: OP_ACK, cls: '0, src: src, dst: dst, err: ERR_OK};
    map_we  = 1'b0;
    case (req)
      REQ_CLEAR: op.kind = OP_CLEAR;
      REQ_RULE: begin
        if (bad_state) begin
          op.err = ERR_STATE;
        end else if (ch == CHAR_WILD) begin
          op.kind = OP_WILD;
        end else if (map_hit) begin
          op.kind = OP_WRITE;
          op.cls  = {1'b0, map_rd};
        end else if (next_class >= cfg.class_count) begin
          op.err = ERR_CLASS;
        end else begin
          op.kind = OP_WRITE;
          op.cls  = next_class;
          map_we  = op_push;
        end
      end
      REQ_TEXT: begin
        op.kind = OP_STEP;
        op.cls  = (cls_raw > cfg.class_count) ? cfg.class_count : cls_raw;
      end
      REQ_END: op.kind = OP_REPORT;
      default: op.kind = OP_ACK;
    endcase
  end

endmodule

// ===== sv/edfa_back.sv =====
// back end: transition table, text walk and result generation
module edfa_back #(
  parameter int BLOCK_LEN = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  edfa_pkg::cfg_t cfg,
  output logic           sweeping,
  input  logic           op_empty,
  input  edfa_pkg::op_t  op,
  output logic           op_pop,
  input  logic           res_full,
  output logic           res_push,
  output edfa_pkg::res_t res
);
  import edfa_pkg::*;

  localparam int POS_W = $clog2(BLOCK_LEN + 1);

  back_state_t        state;
  back_state_t        state_next;
  logic [STATE_W-1:0] table_mem [TABLE_DEPTH];
  logic [STATE_W-1:0] rd_data;
  logic               we;
  logic [TABLE_AW-1:0] wa;
  logic [STATE_W-1:0] wd;
  logic [TABLE_AW-1:0] ra;
  logic [TABLE_AW-1:0] sweep_addr;
  logic [TABLE_AW-1:0] sweep_addr_next;
  logic [CLASS_W-1:0] row;
  logic [CLASS_W-1:0] row_next;
  logic [STATE_W-1:0] wsrc;
  logic [STATE_W-1:0] wdst;
  logic [STATE_W-1:0] cur;
  logic [STATE_W-1:0] cur_next;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_next;
  logic               seg_start;

  assign sweeping  = state == B_SWEEP;
  assign seg_start = pos >= POS_W'(BLOCK_LEN);

  always_ff @(posedge clk) begin
    if (we) table_mem[wa] <= wd;
    rd_data <= table_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_SWEEP;
      sweep_addr <= '0;
      cur        <= '0;
      pos        <= '0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      cur        <= cur_next;
      pos        <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    if (op_pop && op.kind == OP_WILD) begin
      wsrc <= op.src;
      wdst <= op.dst;
    end
  end

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    row_next        = row;
    cur_next        = cur;
    pos_next        = pos;
    we              = 1'b0;
    wa              = sweep_addr;
    wd              = '0;
    ra              = {op.cls, (seg_start ? STATE_W'(0) : cur)};
    op_pop          = 1'b0;
    res_push        = 1'b0;
    res             = '{kind: RES_ACK, state: '0, err: op.err};
    case (state)
      B_SWEEP: begin
        we              = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == TABLE_AW'(TABLE_DEPTH - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!op_empty) begin
          case (op.kind)
            OP_CLEAR: begin
              op_pop          = 1'b1;
              sweep_addr_next = '0;
              state_next      = B_SWEEP;
            end
            OP_WRITE: begin
              if (!res_full) begin
                op_pop   = 1'b1;
                res_push = 1'b1;
                we       = 1'b1;
                wa       = {op.cls, op.src};
                wd       = op.dst;
              end
            end
            OP_WILD: begin
              op_pop     = 1'b1;
              row_next   = '0;
              state_next = B_WILD;
            end
            OP_STEP: begin
              op_pop     = 1'b1;
              cur_next   = seg_start ? '0 : cur;
              pos_next   = seg_start ? POS_W'(1) : pos + 1'b1;
              state_next = B_LOOK;
            end
            OP_ACK: begin
              if (!res_full) begin
                op_pop   = 1'b1;
                res_push = 1'b1;
              end
            end
            OP_REPORT: begin
              if (!res_full) begin
                op_pop   = 1'b1;
                res_push = 1'b1;
                res      = '{kind: RES_FINAL, state: cur, err: ERR_OK};
                cur_next = '0;
                pos_next = '0;
              end
            end
            default: op_pop = 1'b1;
          endcase
        end
      end
      B_WILD: begin
        we  = 1'b1;
        wa  = {row, wsrc};
        wd  = wdst;
        res = '{kind: RES_ACK, state: '0, err: ERR_OK};
        if (row >= cfg.class_count) begin
          if (!res_full) begin
            res_push   = 1'b1;
            state_next = B_IDLE;
          end
        end else begin
          row_next = row + 1'b1;
        end
      end
      B_LOOK: begin
        cur_next   = rd_data;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_res_space: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into full queue");
  a_look_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == B_LOOK |-> $past(state) == B_IDLE && $past(op_pop))
    else $error("table lookup without a step request");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst) pos <= POS_W'(BLOCK_LEN))
    else $error("segment position overrun");
  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    state == B_SWEEP && sweep_addr == TABLE_AW'(TABLE_DEPTH - 1) |=> state == B_IDLE)
    else $error("table sweep did not end");
`endif

endmodule

// ===== sv/enumerative_dfa_runner_core.sv =====
// top level of the enumerative dfa runner: config registers, front, queues and back
// Requests of type clear, rule, text byte and end of text enter through a push/full
// queue port; rules and end of text each return one result through empty/pop.
// A text byte passes the front (class lookup) and then the back (one registered
// transition table read); neither takes a new byte before it is through with the
// last one. A wildcard rule makes the back write its dst into class rows 0 through
// class_count of its src state. After reset and after every clear request the back
// sweeps the 2112-entry transition table, one entry per cycle; full stays high during
// every sweep, so a clear request holds later requests at the input and in the queues
// until the sweep ends. The result of end of text is the state reached in the last
// segment of at most BLOCK_LEN bytes, which starts from state 0.
module enumerative_dfa_runner_core #(
  parameter int BLOCK_LEN = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [5:0]  rule_src,
  input  logic [7:0]  rule_char,
  input  logic [5:0]  rule_dst,
  input  logic [7:0]  text_char,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [5:0]  final_state,
  output logic [1:0]  rule_error
);
  import edfa_pkg::*;

  cfg_t cfg;
  logic cfg_we;
  logic sweeping;
  logic op_push;
  logic op_full;
  logic op_empty;
  logic op_pop;
  op_t  op_in;
  op_t  op_out;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;
  logic [6:0] wr_states;
  logic [5:0] wr_classes;

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign wr_states  = pwdata[6:0];
  assign wr_classes = pwdata[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.state_count <= 7'd1;
      cfg.class_count <= CLASS_W'(MAX_CLASSES);
    end else if (cfg_we) begin
      case (paddr[2])
        CFG_STATES: begin
          if (wr_states == 7'd0) cfg.state_count <= 7'd1;
          else if (wr_states > 7'(MAX_STATES)) cfg.state_count <= 7'(MAX_STATES);
          else cfg.state_count <= wr_states;
        end
        CFG_CLASSES: begin
          if (wr_classes == 6'd0) cfg.class_count <= 6'd1;
          else if (wr_classes > 6'(MAX_CLASSES)) cfg.class_count <= 6'(MAX_CLASSES);
          else cfg.class_count <= wr_classes;
        end
        default: cfg.state_count <= cfg.state_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_STATES:  prdata = {25'd0, cfg.state_count};
      CFG_CLASSES: prdata = {26'd0, cfg.class_count};
      default:     prdata = '0;
    endcase
  end

  edfa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .hold     (sweeping),
    .full     (full),
    .req_type (req_type),
    .rule_src (rule_src),
    .rule_char(rule_char),
    .rule_dst (rule_dst),
    .text_char(text_char),
    .op_full  (op_full),
    .op_push  (op_push),
    .op       (op_in)
  );

  edfa_queue #(.T(op_t)) u_op_queue (
    .clk  (clk),
    .rst  (rst),
    .push (op_push),
    .wdata(op_in),
    .full (op_full),
    .pop  (op_pop),
    .empty(op_empty),
    .rdata(op_out)
  );

  edfa_back #(.BLOCK_LEN(BLOCK_LEN)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .sweeping(sweeping),
    .op_empty(op_empty),
    .op      (op_out),
    .op_pop  (op_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res_in)
  );

  edfa_queue #(.T(res_t)) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .empty(empty),
    .rdata(res_out)
  );

  assign result_kind = res_out.kind;
  assign final_state = res_out.state;
  assign rule_error  = res_out.err;

endmodule
